// ----- rtl/core/sambase_pkg.sv -----
// Shared types and constants for the SAM sequence base checker.
// Used by every module of the block; depends on nothing else.
`timescale 1ns / 1ps

package sambase_pkg;

  localparam int unsigned CfgIndexW = 2;
  localparam int unsigned CfgDataW  = 26;

  localparam logic [CfgIndexW-1:0] RegSeqFieldIndex = 2'd0;
  localparam logic [CfgIndexW-1:0] RegLetterMask    = 2'd1;

  localparam logic [3:0]  SeqFieldIndexReset = 4'd9;
  localparam logic [25:0] LetterMaskReset    = 26'd25048271;

  localparam logic [7:0] ChAt      = 8'h40;
  localparam logic [7:0] ChTab     = 8'h09;
  localparam logic [7:0] ChNewline = 8'h0A;
  localparam logic [7:0] ChSpace   = 8'h20;

  localparam logic [31:0] LineCountMax = 32'hFFFF_FFFF;

  typedef enum logic [1:0] {
    PhStart = 2'd0,
    PhTabs  = 2'd1,
    PhSeq   = 2'd2,
    PhSkip  = 2'd3
  } phase_t;

  typedef struct packed {
    logic [3:0]  seq_field_index;
    logic [25:0] letter_mask;
  } cfg_t;

  typedef struct packed {
    logic [31:0] line_number;
    logic        is_header;
    logic        seq_bad;
    logic [7:0]  bad_byte;
  } result_t;

endpackage

// ----- rtl/core/sambase_cfg_regs.sv -----
// Configuration register file: sequence column index and letter mask.
// Depends on sambase_pkg.
`timescale 1ns / 1ps

module sambase_cfg_regs (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 wr_en,
  input  logic [sambase_pkg::CfgIndexW-1:0]    wr_index,
  input  logic [sambase_pkg::CfgDataW-1:0]     wr_data,
  output sambase_pkg::cfg_t                    cfg
);

  sambase_pkg::cfg_t regs;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.seq_field_index <= sambase_pkg::SeqFieldIndexReset;
      regs.letter_mask     <= sambase_pkg::LetterMaskReset;
    end else if (wr_en) begin
      unique case (wr_index)
        sambase_pkg::RegSeqFieldIndex: begin
          regs.seq_field_index <= wr_data[3:0];
        end
        sambase_pkg::RegLetterMask: begin
          regs.letter_mask <= wr_data[25:0];
        end
        default: begin
        end
      endcase
    end
  end

  assign cfg = regs;

endmodule

// ----- rtl/core/sambase_parser.sv -----
// Per-byte line parser: tracks the field position, checks sequence bytes
// and keeps the line counter. Depends on sambase_pkg.
`timescale 1ns / 1ps

module sambase_parser (
  input  logic                    clk,
  input  logic                    rst,
  input  sambase_pkg::cfg_t       cfg,
  input  logic                    advance,
  input  logic [7:0]              data_byte,
  output sambase_pkg::result_t    result
);

  sambase_pkg::phase_t phase, phase_next;
  logic [3:0]  tabs_seen, tabs_seen_next, tabs_inc;
  logic        header_line, header_line_next;
  logic        bad_found, bad_found_next;
  logic [7:0]  first_bad_byte, first_bad_byte_next;
  logic [31:0] line_counter, line_counter_next;
  logic        check_seq;
  logic        is_alpha;
  logic [4:0]  letter_k;
  logic        letter_ok;

  assign is_alpha  = (data_byte[7:6] == 2'b01) && (data_byte[4:0] != 5'd0)
                     && (data_byte[4:0] <= 5'd26);
  assign letter_k  = is_alpha ? (data_byte[4:0] - 5'd1) : 5'd0;
  assign letter_ok = is_alpha && cfg.letter_mask[letter_k];
  assign tabs_inc  = tabs_seen + 4'd1;

  always_comb begin
    phase_next          = phase;
    tabs_seen_next      = tabs_seen;
    header_line_next    = header_line;
    bad_found_next      = bad_found;
    first_bad_byte_next = first_bad_byte;
    line_counter_next   = line_counter;
    check_seq           = 1'b0;
    if (data_byte == sambase_pkg::ChNewline) begin
      phase_next          = sambase_pkg::PhStart;
      tabs_seen_next      = 4'd0;
      header_line_next    = 1'b0;
      bad_found_next      = 1'b0;
      first_bad_byte_next = sambase_pkg::ChSpace;
      if (line_counter != sambase_pkg::LineCountMax) begin
        line_counter_next = line_counter + 32'd1;
      end
    end else begin
      unique case (phase)
        sambase_pkg::PhStart, sambase_pkg::PhTabs: begin
          if (phase == sambase_pkg::PhStart && data_byte == sambase_pkg::ChAt) begin
            header_line_next = 1'b1;
            phase_next       = sambase_pkg::PhSkip;
          end else begin
            phase_next = sambase_pkg::PhTabs;
            if (tabs_seen >= cfg.seq_field_index) begin
              phase_next = sambase_pkg::PhSeq;
              check_seq  = 1'b1;
            end else if (data_byte == sambase_pkg::ChTab) begin
              tabs_seen_next = tabs_inc;
              if (tabs_inc >= cfg.seq_field_index) begin
                phase_next = sambase_pkg::PhSeq;
              end
            end
          end
        end
        sambase_pkg::PhSeq: begin
          check_seq = 1'b1;
        end
        sambase_pkg::PhSkip: begin
        end
        default: begin
        end
      endcase
      if (check_seq) begin
        if (data_byte == sambase_pkg::ChTab) begin
          phase_next = sambase_pkg::PhSkip;
        end else if (!letter_ok) begin
          bad_found_next      = 1'b1;
          first_bad_byte_next = data_byte;
          phase_next          = sambase_pkg::PhSkip;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= sambase_pkg::PhStart;
      tabs_seen      <= 4'd0;
      header_line    <= 1'b0;
      bad_found      <= 1'b0;
      first_bad_byte <= sambase_pkg::ChSpace;
      line_counter   <= 32'd0;
    end else if (advance) begin
      phase          <= phase_next;
      tabs_seen      <= tabs_seen_next;
      header_line    <= header_line_next;
      bad_found      <= bad_found_next;
      first_bad_byte <= first_bad_byte_next;
      line_counter   <= line_counter_next;
    end
  end

  assign result.line_number = line_counter;
  assign result.is_header   = header_line;
  assign result.seq_bad     = bad_found;
  assign result.bad_byte    = first_bad_byte;

endmodule

// ----- rtl/core/sam_seq_base_checker_top.sv -----
// Top level of the SAM sequence base checker: input register, parser and
// result register. Depends on sambase_pkg, sambase_cfg_regs and sambase_parser.
`timescale 1ns / 1ps

// Usage:
// The input channel (data_byte, in_valid, in_stall) carries one byte of SAM
// text per transfer. Every newline byte yields one result transfer on the
// output channel (line_number, is_header, seq_bad, bad_byte, out_valid,
// out_stall); all other bytes yield nothing.
// A byte is captured in the input register; the parser then updates its
// line state from it and, for a newline, loads the result register.
// The block takes one byte per cycle while no newline waits on a stalled
// result register. A waiting result does not block bytes that produce no
// result; only a newline waits while the result register is full and
// stalled, and the input register then holds it.
// Configuration writes (cfg_valid, cfg_ready, cfg_index, cfg_data) are
// always ready; index 0 is the sequence column index, index 1 the letter
// mask, other indexes are ignored. Write them only while the block is idle.
// Reset clears the parse state, the line counter, both registers' valid
// flags, and restores the configuration defaults.

module sam_seq_base_checker_top (
  input  logic                                clk,
  input  logic                                rst,
  input  logic [7:0]                          data_byte,
  input  logic                                in_valid,
  output logic                                in_stall,
  output logic [31:0]                         line_number,
  output logic                                is_header,
  output logic                                seq_bad,
  output logic [7:0]                          bad_byte,
  output logic                                out_valid,
  input  logic                                out_stall,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [sambase_pkg::CfgIndexW-1:0]   cfg_index,
  input  logic [sambase_pkg::CfgDataW-1:0]    cfg_data
);

  sambase_pkg::cfg_t    cfg;
  sambase_pkg::result_t parse_result;
  sambase_pkg::result_t out_reg;

  logic       hold_valid;
  logic [7:0] hold_byte;
  logic       hold_is_nl;
  logic       advance;
  logic       in_accept;
  logic       emit;

  assign cfg_ready  = 1'b1;
  assign hold_is_nl = (hold_byte == sambase_pkg::ChNewline);
  assign advance    = hold_valid && (!hold_is_nl || !out_valid || !out_stall);
  assign emit       = advance && hold_is_nl;
  assign in_stall   = hold_valid && !advance;
  assign in_accept  = in_valid && !in_stall;

  sambase_cfg_regs u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  sambase_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .advance   (advance),
    .data_byte (hold_byte),
    .result    (parse_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (in_accept) begin
      hold_valid <= 1'b1;
    end else if (advance) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      hold_byte <= data_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_reg <= parse_result;
    end
  end

  assign line_number = out_reg.line_number;
  assign is_header   = out_reg.is_header;
  assign seq_bad     = out_reg.seq_bad;
  assign bad_byte    = out_reg.bad_byte;

endmodule

// ----- rtl/core/sambase_checker.sv -----
// Port-level checks for the SAM sequence base checker, bound to the top level.
// Depends on sambase_pkg and sam_seq_base_checker_top.
`timescale 1ns / 1ps

module sambase_checker (
  input logic        clk,
  input logic        rst,
  input logic [31:0] line_number,
  input logic        is_header,
  input logic        seq_bad,
  input logic [7:0]  bad_byte,
  input logic        out_valid,
  input logic        out_stall
);

  a_reset_clears_out: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  a_out_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(line_number)
      && $stable(bad_byte) && $stable(seq_bad) && $stable(is_header))
    else $error("stalled result changed");

  a_clean_line_space: assert property (@(posedge clk) disable iff (rst)
    out_valid && !seq_bad |-> bad_byte == sambase_pkg::ChSpace)
    else $error("bad byte set on a clean line");

  a_header_not_bad: assert property (@(posedge clk) disable iff (rst)
    out_valid && is_header |-> !seq_bad)
    else $error("header line reported bad");

  a_line_sequence: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && line_number != sambase_pkg::LineCountMax
      |=> !out_valid || line_number == $past(line_number) + 32'd1)
    else $error("line numbers out of order");

endmodule

bind sam_seq_base_checker_top sambase_checker u_sambase_checker (
  .clk         (clk),
  .rst         (rst),
  .line_number (line_number),
  .is_header   (is_header),
  .seq_bad     (seq_bad),
  .bad_byte    (bad_byte),
  .out_valid   (out_valid),
  .out_stall   (out_stall)
);
